/* hdl/drrip_pkg.sv */
`default_nettype none

package drrip_pkg;

    localparam int NUM_SETS     = 2048;
    localparam int WAYS         = 16;
    localparam int LEADER_SETS  = 64;
    localparam int SELECTOR_MAX = 1023;

    localparam int SET_W  = $clog2(NUM_SETS);
    localparam int WAY_W  = 4;
    localparam int SEL_W  = $clog2(SELECTOR_MAX + 1);
    localparam int LFSR_W = 16;
    localparam int MASK_W = 16;

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    typedef logic [SET_W-1:0]  set_t;
    typedef logic [WAY_W-1:0]  way_t;
    typedef logic [SEL_W-1:0]  sel_t;
    typedef logic [LFSR_W-1:0] lfsr_t;

    typedef enum logic {
        CMD_VICTIM = 1'b0,
        CMD_UPDATE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_INVALID = 2'd0,
        KIND_DEAD    = 2'd1,
        KIND_AGED    = 2'd2
    } kind_t;

    typedef struct packed {
        logic [WAYS-1:0][1:0] ru;
        logic [WAYS-1:0][1:0] rr;
    } row_t;

    localparam row_t RESET_ROW = '{ru: '0, rr: '1};

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic is_victim;
        logic out_busy;
    } dp_status_t;

    function automatic lfsr_t lfsr_step(input lfsr_t cur);
        lfsr_t nxt;
        nxt = cur >> 1;
        if (cur[0])
        begin
            nxt = nxt ^ LFSR_TAPS;
        end
        return nxt;
    endfunction

    function automatic way_t first_one(input logic [WAYS-1:0] vec);
        way_t   idx;
        logic   found;
        idx   = '0;
        found = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (vec[w] && !found)
            begin
                idx   = WAY_W'(w);
                found = 1'b1;
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

/* hdl/drrip_ctrl.sv */
`default_nettype none

module drrip_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire drrip_pkg::dp_status_t status,
    output drrip_pkg::dp_cmd_t        cmd
);
    import drrip_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   commit_ok;

    assign commit_ok = !(status.is_victim && status.out_busy);
    assign in_ready  = ready_reg;

    always_comb
    begin
        state_next       = state_reg;
        ready_next       = ready_reg;
        cmd.clear_step   = 1'b0;
        cmd.capture      = 1'b0;
        cmd.commit       = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CALC;
                    ready_next  = 1'b0;
                end
            end
            ST_CALC:
            begin
                if (commit_ok)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                ready_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/drrip_dpath.sv */
`default_nettype none

module drrip_dpath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire drrip_pkg::dp_cmd_t     cmd,
    output drrip_pkg::dp_status_t       status,
    input  wire drrip_pkg::cmd_t        in_cmd,
    input  wire drrip_pkg::set_t        in_set,
    input  wire drrip_pkg::way_t        in_way,
    input  wire logic                   in_hit,
    input  wire logic [drrip_pkg::MASK_W-1:0] in_mask,
    input  wire logic                   cfg_we,
    input  wire drrip_pkg::lfsr_t       cfg_seed,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output drrip_pkg::way_t             out_way,
    output drrip_pkg::kind_t            out_kind
);
    import drrip_pkg::*;

    row_t mem [NUM_SETS];

    set_t  clr_cnt_reg;
    row_t  rd_row_reg;
    cmd_t  cmd_reg;
    set_t  set_reg;
    way_t  way_reg;
    logic  hit_reg;
    logic [MASK_W-1:0] mask_reg;
    lfsr_t lfsr_reg, lfsr_next;
    sel_t  sel_reg, sel_next;
    logic  out_valid_reg;
    way_t  out_way_reg;
    kind_t out_kind_reg;

    logic [WAYS-1:0] invalid_vec, dead_vec, aged_vec;
    logic [WAYS-1:0] any3_vec, hi_vec, lo_vec;
    logic [1:0]      top, delta;
    row_t            aged_row, upd_row, new_row;
    way_t            res_way;
    kind_t           res_kind;
    logic            wr_en;
    logic            in_srrip_lead, in_brrip_lead, use_brrip, way_ok;
    lfsr_t           lfsr_stepped;
    logic [1:0]      ins_val;

    assign status.clear_last = (clr_cnt_reg == SET_W'(NUM_SETS - 1));
    assign status.is_victim  = (cmd_reg == CMD_VICTIM);
    assign status.out_busy   = out_valid_reg && !out_ready;

    assign in_srrip_lead = (set_reg < SET_W'(LEADER_SETS));
    assign in_brrip_lead = !in_srrip_lead && (set_reg < SET_W'(2 * LEADER_SETS));
    assign way_ok        = (32'(way_reg) < WAYS);
    assign lfsr_stepped  = lfsr_step(lfsr_reg);
    assign ins_val       = (lfsr_stepped[4:0] == 5'd0) ? 2'd1 : 2'd3;

    // victim search
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            invalid_vec[w] = (w < MASK_W) ? !mask_reg[w] : 1'b0;
            dead_vec[w]    = (rd_row_reg.ru[w] == 2'd0) && (rd_row_reg.rr[w] == 2'd3);
            any3_vec[w]    = (rd_row_reg.rr[w] == 2'd3);
            hi_vec[w]      = rd_row_reg.rr[w][1];
            lo_vec[w]      = rd_row_reg.rr[w][0];
        end
        priority if (|any3_vec)
            top = 2'd3;
        else if (|hi_vec)
            top = 2'd2;
        else if (|lo_vec)
            top = 2'd1;
        else
            top = 2'd0;
        delta    = 2'd3 - top;
        aged_row = rd_row_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            aged_row.rr[w] = rd_row_reg.rr[w] + delta;
            aged_vec[w]    = (rd_row_reg.rr[w] == top);
        end
        priority if (|invalid_vec)
        begin
            res_way  = first_one(invalid_vec);
            res_kind = KIND_INVALID;
        end
        else if (|dead_vec)
        begin
            res_way  = first_one(dead_vec);
            res_kind = KIND_DEAD;
        end
        else
        begin
            res_way  = first_one(aged_vec);
            res_kind = KIND_AGED;
        end
    end

    // update and selector logic
    always_comb
    begin
        upd_row   = rd_row_reg;
        sel_next  = sel_reg;
        lfsr_next = lfsr_reg;
        use_brrip = 1'b0;
        if (hit_reg)
        begin
            upd_row.rr[way_reg] = 2'd0;
            if (rd_row_reg.ru[way_reg] != 2'd3)
            begin
                upd_row.ru[way_reg] = rd_row_reg.ru[way_reg] + 2'd1;
            end
            if (in_srrip_lead)
            begin
                if (sel_reg != SEL_W'(SELECTOR_MAX))
                begin
                    sel_next = sel_reg + SEL_W'(1);
                end
            end
            else if (in_brrip_lead)
            begin
                if (sel_reg != '0)
                begin
                    sel_next = sel_reg - SEL_W'(1);
                end
            end
        end
        else
        begin
            use_brrip = in_brrip_lead
                     || (!in_srrip_lead && (sel_reg < SEL_W'(SELECTOR_MAX / 2)));
            upd_row.rr[way_reg] = use_brrip ? ins_val : 2'd1;
            upd_row.ru[way_reg] = 2'd0;
            if (use_brrip)
            begin
                lfsr_next = lfsr_stepped;
            end
        end
    end

    always_comb
    begin
        if (cmd_reg == CMD_VICTIM)
        begin
            new_row = aged_row;
            wr_en   = (res_kind == KIND_AGED);
        end
        else
        begin
            new_row = upd_row;
            wr_en   = way_ok;
        end
    end

    // set row memory
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            mem[clr_cnt_reg] <= RESET_ROW;
        end
        else if (cmd.commit && wr_en)
        begin
            mem[set_reg] <= new_row;
        end
        if (cmd.capture)
        begin
            rd_row_reg <= mem[in_set];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= in_cmd;
            set_reg  <= in_set;
            way_reg  <= in_way;
            hit_reg  <= in_hit;
            mask_reg <= in_mask;
        end
        if (cmd.commit && (cmd_reg == CMD_VICTIM))
        begin
            out_way_reg  <= res_way;
            out_kind_reg <= res_kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            lfsr_reg      <= lfsr_t'(1);
            sel_reg       <= SEL_W'(SELECTOR_MAX / 2);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            end
            if (cfg_we)
            begin
                lfsr_reg <= (cfg_seed == '0) ? lfsr_t'(1) : cfg_seed;
            end
            else if (cmd.commit && (cmd_reg == CMD_UPDATE) && way_ok)
            begin
                lfsr_reg <= lfsr_next;
            end
            if (cmd.commit && (cmd_reg == CMD_UPDATE) && way_ok)
            begin
                sel_reg <= sel_next;
            end
            if (cmd.commit && (cmd_reg == CMD_VICTIM))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_way   = out_way_reg;
    assign out_kind  = out_kind_reg;

endmodule

`default_nettype wire

/* hdl/drrip_dead_block_replacement.sv */
// result: a victim result is registered at the commit of its item, after its
//   set row has been read, and is held until m_axis_tready is high
// items: one item is in work at a time, a read-modify-write of one row
//   of the single-port set memory; an update item gives no result, and a victim
//   item also waits as long as the previous result is still held
// reset: asynchronous, active low; afterwards a clearing pass writes all 2048
//   set rows, one a cycle, and no item is taken until the pass is done
`default_nettype none

module drrip_dead_block_replacement (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // set_index, way_index, was_hit, valid_mask
    input  wire logic        s_axis_tuser,  // cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // victim_way
    output logic [1:0]       m_axis_tuser,  // victim_kind
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data       // random_seed
);
    import drrip_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;
    way_t       out_way;
    kind_t      out_kind;

    assign cfg_ready = 1'b1;

    drrip_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    drrip_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .in_cmd    (cmd_t'(s_axis_tuser)),
        .in_set    (s_axis_tdata[10:0]),
        .in_way    (s_axis_tdata[14:11]),
        .in_hit    (s_axis_tdata[15]),
        .in_mask   (s_axis_tdata[31:16]),
        .cfg_we    (cfg_valid),
        .cfg_seed  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_way   (out_way),
        .out_kind  (out_kind)
    );

    assign m_axis_tdata = {4'b0000, out_way};
    assign m_axis_tuser = out_kind;

endmodule

`default_nettype wire

/* hdl/drrip_checker.sv */
`default_nettype none

module drrip_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);
    import drrip_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
    else $error("stalled result changed");

    // kind code and way field stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'd3) && (m_axis_tdata[7:4] == 4'd0))
    else $error("bad result encoding");

    // a new result follows an accepted victim request, through the calc state and the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |->
            $past(s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_VICTIM), 2))
    else $error("result without victim request");

    // one item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item taken while busy");

endmodule

bind drrip_dead_block_replacement drrip_checker u_drrip_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* verif/drrip_victim_checker.sv */
`timescale 1ns / 1ps

module drrip_victim_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // set_index, way_index, was_hit, valid_mask
    input  wire logic        s_axis_tuser,  // cmd
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [7:0]  m_axis_tdata,  // victim_way
    input  wire logic [1:0]  m_axis_tuser,  // victim_kind
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [15:0] cfg_data,      // random_seed
    output int               fail_count,
    output int               pending,
    output int               invalid_picks,
    output int               dead_picks,
    output int               aged_picks
);
    import drrip_pkg::*;

    typedef struct packed {
        way_t  way;
        kind_t kind;
    } victim_pick_t;

    logic [1:0]   rrpv_tab  [NUM_SETS][WAYS];
    logic [1:0]   reuse_tab [NUM_SETS][WAYS];
    sel_t         duel_count;
    lfsr_t        lfsr_state;
    victim_pick_t pending_picks [$];
    int           fail_tally;
    int           invalid_tally;
    int           dead_tally;
    int           aged_tally;

    // galois step, then one in 32 chance of a near insertion
    function automatic logic [1:0] brrip_insert();
        lfsr_state = (lfsr_state >> 1) ^ (lfsr_state[0] ? LFSR_TAPS : lfsr_t'(0));
        return (lfsr_state[4:0] == 5'd0) ? 2'd1 : 2'd3;
    endfunction

    task automatic predict_victim(input set_t s, input logic [MASK_W-1:0] mask);
        victim_pick_t pick;
        logic         found;
        logic [1:0]   top;
        found     = 1'b0;
        top       = 2'd0;
        pick.way  = '0;
        pick.kind = KIND_AGED;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && !mask[w])
            begin
                pick.way  = way_t'(w);
                pick.kind = KIND_INVALID;
                found     = 1'b1;
            end
        end
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && reuse_tab[s][w] == 2'd0 && rrpv_tab[s][w] == 2'd3)
            begin
                pick.way  = way_t'(w);
                pick.kind = KIND_DEAD;
                found     = 1'b1;
            end
        end
        if (!found)
        begin
            // age the whole set at once so the oldest way lands on 3
            for (int w = 0; w < WAYS; w++)
            begin
                if (rrpv_tab[s][w] > top)
                begin
                    top = rrpv_tab[s][w];
                end
            end
            for (int w = 0; w < WAYS; w++)
            begin
                rrpv_tab[s][w] = rrpv_tab[s][w] + (2'd3 - top);
            end
            for (int w = 0; w < WAYS; w++)
            begin
                if (!found && rrpv_tab[s][w] == 2'd3)
                begin
                    pick.way  = way_t'(w);
                    pick.kind = KIND_AGED;
                    found     = 1'b1;
                end
            end
        end
        pending_picks.insert(pending_picks.size(), pick);
    endtask

    task automatic apply_access(input set_t s, input way_t w, input logic hit);
        if (hit)
        begin
            rrpv_tab[s][w] = 2'd0;
            if (reuse_tab[s][w] != 2'd3)
            begin
                reuse_tab[s][w] = reuse_tab[s][w] + 2'd1;
            end
            if (s < LEADER_SETS)
            begin
                if (duel_count != sel_t'(SELECTOR_MAX))
                begin
                    duel_count = duel_count + 1'b1;
                end
            end
            else if (s < 2 * LEADER_SETS)
            begin
                if (duel_count != '0)
                begin
                    duel_count = duel_count - 1'b1;
                end
            end
        end
        else
        begin
            if (s < LEADER_SETS)
            begin
                rrpv_tab[s][w] = 2'd1;
            end
            else if (s < 2 * LEADER_SETS)
            begin
                rrpv_tab[s][w] = brrip_insert();
            end
            else if (duel_count >= sel_t'(SELECTOR_MAX / 2))
            begin
                rrpv_tab[s][w] = 2'd1;
            end
            else
            begin
                rrpv_tab[s][w] = brrip_insert();
            end
            reuse_tab[s][w] = 2'd0;
        end
    endtask

    task automatic take_item(input logic [31:0] data, input logic user);
        set_t              s;
        way_t              w;
        logic              hit;
        logic [MASK_W-1:0] mask;
        s    = data[10:0];
        w    = data[14:11];
        hit  = data[15];
        mask = data[31:16];
        if (cmd_t'(user) == CMD_VICTIM)
        begin
            predict_victim(s, mask);
        end
        else
        begin
            apply_access(s, w, hit);
        end
    endtask

    task automatic check_pick(input logic [7:0] way_bits, input logic [1:0] kind_bits);
        victim_pick_t want;
        if (pending_picks.size() == 0)
        begin
            $error("victim result with nothing expected: victim_way %0d victim_kind %0d",
                   way_bits, kind_bits);
            fail_tally++;
        end
        else
        begin
            want = pending_picks.pop_front();
            if (way_bits != {4'b0000, want.way})
            begin
                $error("victim_way mismatch: expected %0d, actual %0d", want.way, way_bits);
                fail_tally++;
            end
            if (kind_bits != want.kind)
            begin
                $error("victim_kind mismatch: expected %0d, actual %0d", want.kind, kind_bits);
                fail_tally++;
            end
            unique case (want.kind)
                KIND_INVALID: invalid_tally++;
                KIND_DEAD:    dead_tally++;
                default:      aged_tally++;
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SETS; s++)
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    rrpv_tab[s][w]  = 2'd3;
                    reuse_tab[s][w] = 2'd0;
                end
            end
            duel_count = sel_t'(SELECTOR_MAX / 2);
            lfsr_state = lfsr_t'(1);
            pending_picks.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_pick(m_axis_tdata, m_axis_tuser);
            end
            if (cfg_valid && cfg_ready)
            begin
                // a zero seed would lock the lfsr
                lfsr_state = (cfg_data == '0) ? lfsr_t'(1) : cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                take_item(s_axis_tdata, s_axis_tuser);
            end
        end
        fail_count    <= fail_tally;
        pending       <= pending_picks.size();
        invalid_picks <= invalid_tally;
        dead_picks    <= dead_tally;
        aged_picks    <= aged_tally;
    end

endmodule

/* verif/tb_drrip_dead_block_replacement.sv */
`timescale 1ns / 1ps

module tb_drrip_dead_block_replacement;
    import drrip_pkg::*;

    localparam int LIMIT = 300000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    int   fail_count;
    int   pending;
    int   invalid_picks;
    int   dead_picks;
    int   aged_picks;
    int   cycle_count;
    int   items_sent;
    int   seeds_used;
    bit   src_quiet;
    bit   sink_quiet;
    set_t work_sets [24];

    drrip_dead_block_replacement dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    drrip_victim_checker victim_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("** drrip_dead_block_replacement: FAILED **");
            $finish;
        end
    end

    // result side: random stalls with occasional stretches of none
    initial
    begin
        int stall;
        int taken;
        taken         = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            if (taken % 40 == 0)
            begin
                sink_quiet = ($urandom_range(0, 3) == 0);
            end
            stall = sink_quiet ? 0 : $urandom_range(0, 12);
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            taken++;
        end
    end

    task automatic issue_lookup(input cmd_t cmd, input set_t s, input way_t w,
                                input logic hit, input logic [MASK_W-1:0] mask);
        int gap;
        if (items_sent % 40 == 0)
        begin
            src_quiet = ($urandom_range(0, 3) == 0);
        end
        gap = src_quiet ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {mask, hit, w, s};
        s_axis_tuser  <= cmd;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // hold off until every victim choice is back and updates have drained
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic write_seed(input logic [15:0] seed);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= seed;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        seeds_used++;
    endtask

    task automatic random_lookup(input int tilt);
        int                r;
        set_t              s;
        cmd_t              cmd;
        logic [MASK_W-1:0] mask;
        r = $urandom_range(0, 99);
        if (tilt != 0 && r < 85)
        begin
            // leader hits to push the duel selector toward one end
            s = (tilt > 0) ? set_t'($urandom_range(0, LEADER_SETS - 1))
                           : set_t'($urandom_range(LEADER_SETS, 2 * LEADER_SETS - 1));
            issue_lookup(CMD_UPDATE, s, way_t'($urandom_range(0, 15)), 1'b1,
                         MASK_W'($urandom_range(0, 65535)));
        end
        else
        begin
            s   = ($urandom_range(0, 9) == 0) ? set_t'($urandom_range(0, NUM_SETS - 1))
                                              : work_sets[$urandom_range(0, 23)];
            cmd = ($urandom_range(0, 99) < 40) ? CMD_VICTIM : CMD_UPDATE;
            r   = $urandom_range(0, 99);
            if (cmd == CMD_UPDATE || r >= 85)
            begin
                mask = MASK_W'($urandom_range(0, 65535));
            end
            else if (r < 70)
            begin
                mask = '1;
            end
            else
            begin
                mask = ~(MASK_W'(1) << $urandom_range(0, 15));
            end
            issue_lookup(cmd, s, way_t'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                         mask);
        end
    endtask

    task automatic run_phase(input int count, input int tilt);
        for (int i = 0; i < 8; i++)
        begin
            work_sets[i]      = set_t'($urandom_range(0, LEADER_SETS - 1));
            work_sets[i + 8]  = set_t'($urandom_range(LEADER_SETS, 2 * LEADER_SETS - 1));
            work_sets[i + 16] = set_t'($urandom_range(2 * LEADER_SETS, NUM_SETS - 1));
        end
        repeat (count) random_lookup(tilt);
        settle();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // invalid ways at both ends of the mask, a dead way, hits and fills
        issue_lookup(CMD_VICTIM, 0, 0, 1'b0, 16'h0000);
        issue_lookup(CMD_VICTIM, 2047, 15, 1'b1, 16'h7FFF);
        issue_lookup(CMD_VICTIM, 128, 0, 1'b0, 16'hFFFF);
        issue_lookup(CMD_UPDATE, 0, 0, 1'b1, 16'h0000);
        issue_lookup(CMD_UPDATE, 127, 15, 1'b1, 16'hFFFF);
        issue_lookup(CMD_UPDATE, 64, 15, 1'b0, 16'h0000);
        issue_lookup(CMD_UPDATE, 2047, 0, 1'b0, 16'hFFFF);
        issue_lookup(CMD_VICTIM, 0, 15, 1'b1, 16'hFFFF);
        // fill a whole set, then force aging and a dead pick right after
        for (int w = 0; w < WAYS; w++)
        begin
            issue_lookup(CMD_UPDATE, 5, way_t'(w), 1'b0, 16'h0000);
        end
        repeat (2) issue_lookup(CMD_VICTIM, 5, 0, 1'b0, 16'hFFFF);
        settle();

        write_seed(16'h0000);
        run_phase(330, 0);
        write_seed(16'hFFFF);
        run_phase(650, -1);
        write_seed(16'($urandom_range(2, 65534)));
        run_phase(350, 0);
        write_seed(16'h0001);
        run_phase(200, 0);

        $display("run covered %0d lookups and updates over %0d seed settings",
                 items_sent, seeds_used + 1);
        $display("victim choices checked: %0d invalid way, %0d dead block, %0d aged set",
                 invalid_picks, dead_picks, aged_picks);
        if (fail_count == 0)
        begin
            $display("** drrip_dead_block_replacement: PASSED **");
        end
        else
        begin
            $display("** drrip_dead_block_replacement: FAILED **");
        end
        $finish;
    end

endmodule
